// File: rtl/tkcs_pkg.sv
// ----------------------------------------------------------------------------
// tkcs_pkg
// Shared constants and types for the top-k class score selector.
// ----------------------------------------------------------------------------
package tkcs_pkg;

  localparam int MAX_K_DEFAULT       = 16;
  localparam int MAX_CLASSES_DEFAULT = 2048;

  localparam int SCORE_W = 32;
  localparam int ID_W    = 11;
  localparam int COUNT_W = 11;
  localparam int TOPK_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1000;
  localparam logic [TOPK_W-1:0]  TOPK_RESET  = 5'd5;

  localparam logic REG_CLASS_COUNT = 1'b0;
  localparam logic REG_TOP_K       = 1'b1;

  typedef struct packed {
    logic insert;
    logic clear;
    logic shift_out;
  } ctrl_cmd_t;

  // Order-preserving key; both zeros map to the same key.
  function automatic logic [SCORE_W-1:0] order_key(input logic [SCORE_W-1:0] bits);
    logic [SCORE_W-1:0] b;
    b = (bits[SCORE_W-2:0] == '0) ? '0 : bits;
    return b[SCORE_W-1] ? ~b : (b | {1'b1, {(SCORE_W-1){1'b0}}});
  endfunction

endpackage

// File: rtl/tkcs_datapath.sv
// ----------------------------------------------------------------------------
// tkcs_datapath
// Ranked list with parallel compare-and-shift insertion and shift-out read.
// ----------------------------------------------------------------------------
module tkcs_datapath #(
  parameter int MAX_K = tkcs_pkg::MAX_K_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tkcs_pkg::ctrl_cmd_t          cmd,
  input  logic [tkcs_pkg::SCORE_W-1:0] in_score,
  input  logic [tkcs_pkg::ID_W-1:0]    in_id,
  output logic [tkcs_pkg::SCORE_W-1:0] head_score,
  output logic [tkcs_pkg::ID_W-1:0]    head_id,
  output logic [$clog2(MAX_K+1)-1:0]   fill
);

  localparam int FILL_W = $clog2(MAX_K + 1);

  logic [tkcs_pkg::SCORE_W-1:0] scores [MAX_K];
  logic [tkcs_pkg::SCORE_W-1:0] keys   [MAX_K];
  logic [tkcs_pkg::ID_W-1:0]    ids    [MAX_K];
  logic [MAX_K-1:0]             valid;
  logic [MAX_K-1:0]             below;
  logic [tkcs_pkg::SCORE_W-1:0] new_key;

  assign new_key    = tkcs_pkg::order_key(in_score);
  assign head_score = scores[0];
  assign head_id    = ids[0];

  // Entry i takes the new item if it is the first slot where the new key is
  // strictly above the stored one (or empty); entries after it shift down.
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      below[i] = !valid[i] || (keys[i] < new_key);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_K; i++) begin
      if (cmd.insert) begin
        if (below[i]) begin
          if (i == 0 || !below[(i == 0) ? 0 : i-1]) begin
            scores[i] <= in_score;
            keys[i]   <= new_key;
            ids[i]    <= in_id;
          end else begin
            scores[i] <= scores[(i == 0) ? 0 : i-1];
            keys[i]   <= keys[(i == 0) ? 0 : i-1];
            ids[i]    <= ids[(i == 0) ? 0 : i-1];
          end
        end
      end else if (cmd.shift_out) begin
        if (i < MAX_K - 1) begin
          scores[i] <= scores[(i < MAX_K - 1) ? i+1 : i];
          keys[i]   <= keys[(i < MAX_K - 1) ? i+1 : i];
          ids[i]    <= ids[(i < MAX_K - 1) ? i+1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= '0;
      fill  <= '0;
    end else if (cmd.insert) begin
      if (!valid[MAX_K-1]) begin
        valid <= (valid << 1) | MAX_K'(1);
        fill  <= fill + FILL_W'(1);
      end
    end else if (cmd.shift_out) begin
      valid <= valid >> 1;
      fill  <= fill - FILL_W'(1);
    end
  end

endmodule

// File: rtl/tkcs_controller.sv
// ----------------------------------------------------------------------------
// tkcs_controller
// Row position tracking, end-of-row detection and result emission sequencing.
// ----------------------------------------------------------------------------
module tkcs_controller #(
  parameter int MAX_K = tkcs_pkg::MAX_K_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tkcs_pkg::COUNT_W-1:0] class_count,
  input  logic [tkcs_pkg::TOPK_W-1:0]  top_k,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic [tkcs_pkg::ID_W-1:0]    position,
  input  logic [$clog2(MAX_K+1)-1:0]   fill,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_last,
  output tkcs_pkg::ctrl_cmd_t          cmd
);

  localparam int FILL_W = $clog2(MAX_K + 1);
  localparam int K_W    = (FILL_W > tkcs_pkg::TOPK_W) ? FILL_W : tkcs_pkg::TOPK_W;

  localparam logic S_RUN  = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic                          state;
  logic [FILL_W-1:0]             remain;
  logic [tkcs_pkg::COUNT_W-1:0]  count;
  logic                          row_end;
  logic [K_W-1:0]                k_lim;
  logic [K_W-1:0]                fill_after;
  logic [K_W-1:0]                n_out;
  logic                          accept;

  assign count    = (class_count == '0) ? tkcs_pkg::COUNT_W'(1) : class_count;
  assign row_end  = ({1'b0, position} + 12'd1) >= {1'b0, count};
  assign k_lim    = (K_W'(top_k) > K_W'(MAX_K)) ? K_W'(MAX_K) : K_W'(top_k);
  assign fill_after = (fill == FILL_W'(MAX_K)) ? K_W'(fill) : K_W'(fill) + K_W'(1);
  assign n_out    = (k_lim < fill_after) ? k_lim : fill_after;

  assign in_ready  = (state == S_RUN);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == S_EMIT);
  assign out_last  = (remain == FILL_W'(1));

  always_comb begin
    cmd.insert    = accept;
    cmd.shift_out = out_valid && out_ready;
    cmd.clear     = (accept && row_end && n_out == '0) ||
                    (out_valid && out_ready && out_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      remain   <= '0;
      position <= '0;
    end else begin
      case (state)
        S_RUN: begin
          if (accept) begin
            if (row_end) begin
              position <= '0;
              if (n_out != '0) begin
                state  <= S_EMIT;
                remain <= FILL_W'(n_out);
              end
            end else begin
              position <= position + tkcs_pkg::ID_W'(1);
            end
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            remain <= remain - FILL_W'(1);
            if (out_last) state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

endmodule

// File: rtl/topk_class_score_selector_unit.sv
// ----------------------------------------------------------------------------
// topk_class_score_selector_unit
// Streaming top-k selection of class scores, emitted per row in rank order.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_axis   in   tdata[31:0] score
// m_axis   out  tdata[10:0] class_id, [42:11] confidence; tlast row_end
// cfg      in   index 0 class_count, 1 top_k; data
//
// One score per cycle inside a row (parallel compare-and-shift insertion).
// The first result of a row is valid the cycle after its last score transfers;
// the input then stalls until the n-th result transfers, and stays stalled while
// m_axis_tready is low.
// Synchronous reset empties the list, zeroes the row position and loads the
// register defaults.
module topk_class_score_selector_unit #(
  parameter int MAX_K = tkcs_pkg::MAX_K_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // score
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // class_id, confidence, zero pad
  output logic        m_axis_tlast,   // row_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [tkcs_pkg::COUNT_W-1:0] class_count;
  logic [tkcs_pkg::TOPK_W-1:0]  top_k;
  tkcs_pkg::ctrl_cmd_t          cmd;
  logic [tkcs_pkg::ID_W-1:0]    position;
  logic [$clog2(MAX_K+1)-1:0]   fill;
  logic [tkcs_pkg::SCORE_W-1:0] head_score;
  logic [tkcs_pkg::ID_W-1:0]    head_id;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= tkcs_pkg::COUNT_RESET;
      top_k       <= tkcs_pkg::TOPK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tkcs_pkg::REG_CLASS_COUNT: class_count <= cfg_data[tkcs_pkg::COUNT_W-1:0];
        tkcs_pkg::REG_TOP_K:       top_k       <= cfg_data[tkcs_pkg::TOPK_W-1:0];
        default: ;
      endcase
    end
  end

  tkcs_controller #(.MAX_K(MAX_K)) u_ctrl (
    .clk(clk), .rst(rst), .class_count(class_count), .top_k(top_k),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .position(position),
    .fill(fill), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_last(m_axis_tlast), .cmd(cmd)
  );

  tkcs_datapath #(.MAX_K(MAX_K)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_score(s_axis_tdata), .in_id(position),
    .head_score(head_score), .head_id(head_id), .fill(fill)
  );

  assign m_axis_tdata = {5'd0, head_score, head_id};

  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during emission");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= ($clog2(MAX_K+1))'(MAX_K)) else $error("fill overflow");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (fill == '0 && s_axis_tready))
    else $error("list not cleared after row");

endmodule
